// ===== hw/rtl/stb_pkg.sv =====
// ----------------------------------------------------------------------------
// stb_pkg: shared types and codes of the software timer bank
// Transaction structs, operation and event codes, sequencer states.
// ----------------------------------------------------------------------------
package stb_pkg;

	localparam int TIMERS_DEF = 8;
	localparam int TIDX_W     = 6;
	localparam int TIME_W     = 32;
	localparam int KIND_W     = 3;

	localparam logic [1:0] FUNC_START = 2'd0;
	localparam logic [1:0] FUNC_STOP  = 2'd1;
	localparam logic [1:0] FUNC_TICK  = 2'd2;

	localparam logic [KIND_W-1:0] KIND_START_OK  = 3'd0;
	localparam logic [KIND_W-1:0] KIND_START_BAD = 3'd1;
	localparam logic [KIND_W-1:0] KIND_STOP      = 3'd2;
	localparam logic [KIND_W-1:0] KIND_IDLE_TICK = 3'd3;
	localparam logic [KIND_W-1:0] KIND_EXPIRED   = 3'd4;

	typedef struct packed {
		logic [1:0]        func;
		logic [TIDX_W-1:0] timer_index;
		logic [TIME_W-1:0] delay_period;
		logic              is_periodic;
		logic [TIME_W-1:0] tick_span;
	} req_t;

	typedef struct packed {
		logic [KIND_W-1:0] event_kind;
		logic [TIDX_W-1:0] fired_index;
		logic [TIME_W-1:0] now_time;
		logic              last;
	} rsp_t;

	typedef struct packed {
		logic              we_rem;
		logic              we_per;
		logic [TIDX_W-1:0] addr;
		logic [TIME_W-1:0] rem;
		logic [TIME_W-1:0] per;
	} mem_wr_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_FLUSH
	} state_t;

endpackage

// ===== hw/rtl/software_timer_bank.sv =====
// ----------------------------------------------------------------------------
// software_timer_bank: start/stop result registered in the cycle after accept
// tick: each timer is scanned in turn, then the flush state loads the last
// result; one timer per cycle on the store read port and the shared subtract
// unit unless an output stall holds the scan; busy until the tick completes
// reset clears armed and mode flags and the clock; time stores need no clearing
// ----------------------------------------------------------------------------
module software_timer_bank #(
	parameter int TIMERS = stb_pkg::TIMERS_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          req_valid,
	output logic          req_ready,
	input  stb_pkg::req_t req,
	output logic          rsp_valid,
	input  logic          rsp_ready,
	output stb_pkg::rsp_t rsp
);

	localparam int IW = (TIMERS > 1) ? $clog2(TIMERS) : 1;

	stb_pkg::state_t state_q, state_d;

	logic [TIMERS-1:0]          armed_q;
	logic [TIMERS-1:0]          reload_q;
	logic [IW-1:0]              idx_q;
	logic [stb_pkg::TIME_W-1:0] clock_q;
	logic [stb_pkg::TIME_W-1:0] elapsed_q;
	logic                       pend_valid_q;
	logic [IW-1:0]              pend_idx_q;
	logic                       rsp_valid_q;
	stb_pkg::rsp_t              rsp_q;

	stb_pkg::mem_wr_t           mem_wr;
	logic                       mem_re;
	logic [IW-1:0]              mem_raddr;
	logic [stb_pkg::TIME_W-1:0] rd_rem, rd_per;
	logic [stb_pkg::TIME_W-1:0] diff;
	logic                       gt;

	logic          accept, slot_free, idx_ok, is_last_idx;
	logic          armed_cur, expire, emit_pend, advance;
	logic          tick_acc, start_acc, stop_acc, flush_done;
	logic          rsp_load;
	stb_pkg::rsp_t rsp_d;

	stb_time_mem #(.TIMERS(TIMERS)) u_mem (
		.clk    (clk),
		.wr     (mem_wr),
		.re     (mem_re),
		.raddr  (mem_raddr),
		.rd_rem (rd_rem),
		.rd_per (rd_per)
	);

	stb_sub_unit u_sub (
		.a    (rd_rem),
		.b    (elapsed_q),
		.diff (diff),
		.gt   (gt)
	);

	assign slot_free   = !rsp_valid_q || rsp_ready;
	assign req_ready   = (state_q == stb_pkg::ST_IDLE) && slot_free;
	assign accept      = req_valid && req_ready;
	assign idx_ok      = {1'b0, req.timer_index} < 7'(TIMERS);
	assign is_last_idx = idx_q == IW'(TIMERS - 1);
	assign armed_cur   = armed_q[idx_q];
	assign expire      = armed_cur && !gt;
	assign emit_pend   = expire && pend_valid_q;
	assign rsp_valid   = rsp_valid_q;
	assign rsp         = rsp_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= stb_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d    = state_q;
		mem_wr     = '0;
		mem_re     = 1'b0;
		mem_raddr  = '0;
		rsp_load   = 1'b0;
		rsp_d      = '0;
		tick_acc   = 1'b0;
		start_acc  = 1'b0;
		stop_acc   = 1'b0;
		advance    = 1'b0;
		flush_done = 1'b0;
		rsp_d.now_time = clock_q;
		case (state_q)
			stb_pkg::ST_IDLE: begin
				if (accept) begin
					case (req.func)
						stb_pkg::FUNC_START: begin
							rsp_load = 1'b1;
							rsp_d.last = 1'b1;
							if (idx_ok) begin
								start_acc = 1'b1;
								mem_wr.we_rem = 1'b1;
								mem_wr.we_per = 1'b1;
								mem_wr.addr = req.timer_index;
								mem_wr.rem = req.delay_period;
								mem_wr.per = req.delay_period;
								rsp_d.event_kind = stb_pkg::KIND_START_OK;
							end else begin
								rsp_d.event_kind = stb_pkg::KIND_START_BAD;
							end
						end
						stb_pkg::FUNC_STOP: begin
							stop_acc = idx_ok;
							rsp_load = 1'b1;
							rsp_d.last = 1'b1;
							rsp_d.event_kind = stb_pkg::KIND_STOP;
						end
						stb_pkg::FUNC_TICK: begin
							tick_acc = 1'b1;
							mem_re = 1'b1;
							mem_raddr = '0;
							state_d = stb_pkg::ST_SCAN;
						end
						default: begin
						end
					endcase
				end
			end
			stb_pkg::ST_SCAN: begin
				advance = !emit_pend || slot_free;
				if (advance) begin
					mem_wr.we_rem = armed_cur && (gt || reload_q[idx_q]);
					mem_wr.addr = stb_pkg::TIDX_W'(idx_q);
					mem_wr.rem = gt ? diff : rd_per;
					if (emit_pend) begin
						rsp_load = 1'b1;
						rsp_d.event_kind = stb_pkg::KIND_EXPIRED;
						rsp_d.fired_index = stb_pkg::TIDX_W'(pend_idx_q);
						rsp_d.last = 1'b0;
					end
					if (is_last_idx) begin
						state_d = stb_pkg::ST_FLUSH;
					end else begin
						mem_re = 1'b1;
						mem_raddr = idx_q + 1'b1;
					end
				end
			end
			stb_pkg::ST_FLUSH: begin
				if (slot_free) begin
					flush_done = 1'b1;
					rsp_load = 1'b1;
					rsp_d.last = 1'b1;
					if (pend_valid_q) begin
						rsp_d.event_kind = stb_pkg::KIND_EXPIRED;
						rsp_d.fired_index = stb_pkg::TIDX_W'(pend_idx_q);
					end else begin
						rsp_d.event_kind = stb_pkg::KIND_IDLE_TICK;
					end
					state_d = stb_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = stb_pkg::ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			armed_q <= '0;
			reload_q <= '0;
			clock_q <= '0;
			pend_valid_q <= 1'b0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (start_acc) begin
				armed_q[req.timer_index[IW-1:0]] <= 1'b1;
				reload_q[req.timer_index[IW-1:0]] <= req.is_periodic;
			end
			if (stop_acc) begin
				armed_q[req.timer_index[IW-1:0]] <= 1'b0;
			end
			if (advance && expire && !reload_q[idx_q]) begin
				armed_q[idx_q] <= 1'b0;
			end
			if (tick_acc) begin
				clock_q <= clock_q + req.tick_span;
			end
			if (advance && expire) begin
				pend_valid_q <= 1'b1;
			end else if (flush_done) begin
				pend_valid_q <= 1'b0;
			end
			if (rsp_load) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (tick_acc) begin
			elapsed_q <= req.tick_span;
			idx_q <= '0;
		end else if (advance && !is_last_idx) begin
			idx_q <= idx_q + 1'b1;
		end
		if (advance && expire) begin
			pend_idx_q <= idx_q;
		end
		if (rsp_load) begin
			rsp_q <= rsp_d;
		end
	end

	a_busy_not_ready: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != stb_pkg::ST_IDLE) |-> !req_ready)
		else $error("request taken during tick scan");

	a_idle_no_pend: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == stb_pkg::ST_IDLE) |-> !pend_valid_q)
		else $error("pending expiry left after tick");

	a_idle_tick_last: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid && rsp.event_kind == stb_pkg::KIND_IDLE_TICK) |-> rsp.last)
		else $error("idle tick result not marked last");

	a_flush_to_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == stb_pkg::ST_FLUSH && slot_free) |=> (state_q == stb_pkg::ST_IDLE))
		else $error("flush did not complete");

endmodule

// ===== hw/rtl/stb_time_mem.sv =====
// ----------------------------------------------------------------------------
// stb_time_mem: remaining time and period store
// One write port, one registered read port, both stores share the address.
// ----------------------------------------------------------------------------
module stb_time_mem #(
	parameter int TIMERS = stb_pkg::TIMERS_DEF
) (
	input  logic                              clk,
	input  stb_pkg::mem_wr_t                  wr,
	input  logic                              re,
	input  logic [((TIMERS > 1) ? $clog2(TIMERS) : 1)-1:0] raddr,
	output logic [stb_pkg::TIME_W-1:0]        rd_rem,
	output logic [stb_pkg::TIME_W-1:0]        rd_per
);

	localparam int IW = (TIMERS > 1) ? $clog2(TIMERS) : 1;

	logic [stb_pkg::TIME_W-1:0] rem_mem [TIMERS];
	logic [stb_pkg::TIME_W-1:0] per_mem [TIMERS];

	always_ff @(posedge clk) begin
		if (wr.we_rem) begin
			rem_mem[wr.addr[IW-1:0]] <= wr.rem;
		end
		if (wr.we_per) begin
			per_mem[wr.addr[IW-1:0]] <= wr.per;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rd_rem <= rem_mem[raddr];
			rd_per <= per_mem[raddr];
		end
	end

endmodule

// ===== hw/rtl/stb_sub_unit.sv =====
// ----------------------------------------------------------------------------
// stb_sub_unit: shared countdown unit
// Subtracts elapsed time from remaining time and flags remaining above elapsed.
// ----------------------------------------------------------------------------
module stb_sub_unit (
	input  logic [stb_pkg::TIME_W-1:0] a,
	input  logic [stb_pkg::TIME_W-1:0] b,
	output logic [stb_pkg::TIME_W-1:0] diff,
	output logic                       gt
);

	logic [stb_pkg::TIME_W:0] wide;

	assign wide = {1'b0, a} - {1'b0, b};
	assign diff = wide[stb_pkg::TIME_W-1:0];
	assign gt   = !wide[stb_pkg::TIME_W] && (diff != '0);

endmodule
